[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

[hdl/fpdt_pkg.sv]
// ----------------------------------------------------------------------------
// fpdt_pkg
// Constants and types for the fixed-point to decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package fpdt_pkg;

  localparam int FRACTION_DIGITS_DEF = 6;
  localparam int INT_DIGITS          = 5;
  localparam int INT_IDX_W           = $clog2(INT_DIGITS);
  localparam int NDIG_W              = $clog2(INT_DIGITS + 1);

  localparam logic [15:0] DIV10_MUL   = 16'hCCCD;
  localparam int          DIV10_SHIFT = 19;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [2:0] {
    SER_IDLE,
    SER_SIGN,
    SER_INT,
    SER_DOT,
    SER_FRAC
  } ser_state_t;

endpackage

`default_nettype wire

[hdl/fixed_point_to_decimal_text.sv]
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_text
// Converts a signed Q16.16 value into its decimal ASCII text, one character
// per output transfer, with the final fraction digit marked by last.
//
//   Channel  Handshake            Payload
//   input    in_valid, in_stall   value[31:0] signed
//   output   out_valid, out_stall character[7:0], last
//
// A value passes six pipeline stages, then a serializer that sends one
// character per cycle, while the output is not stalled, into the output
// register: an optional minus sign, the integer digits without leading zeros
// (at least one), the point and FRACTION_DIGITS fraction digits. The pipeline
// takes a new value in every cycle it has room. The first character passes the
// pipeline stages, the serializer state register and the output register.
// Reset clears the valid bits and the serializer state; stalls hold all data.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fixed_point_to_decimal_text import fpdt_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              character,
  output logic                    last
);

  localparam int FRAC_IDX_W = (FRACTION_DIGITS > 1) ? $clog2(FRACTION_DIGITS) : 1;
  localparam int IDX_W      = (FRAC_IDX_W > INT_IDX_W) ? FRAC_IDX_W : INT_IDX_W;

  logic                            dig_valid;
  logic                            dig_take;
  logic                            dig_neg;
  logic [INT_DIGITS-1:0][3:0]      dig_int;
  logic [FRACTION_DIGITS-1:0][3:0] dig_frac;

  ser_state_t                      state;
  ser_state_t                      state_next;
  logic [IDX_W-1:0]                idx;
  logic [IDX_W-1:0]                idx_next;
  logic [INT_DIGITS-1:0][3:0]      buf_idig;
  logic [FRACTION_DIGITS-1:0][3:0] buf_fdig;
  logic [NDIG_W-1:0]               buf_ndig;
  logic [NDIG_W-1:0]               ndig_new;
  logic                            emit;
  logic                            last_char;
  logic                            load;
  logic [7:0]                      ch;

  fpdt_digit_pipe #(
    .FRACTION_DIGITS(FRACTION_DIGITS)
  ) u_pipe (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .dig_valid  (dig_valid),
    .dig_take   (dig_take),
    .neg        (dig_neg),
    .int_digits (dig_int),
    .frac_digits(dig_frac)
  );

  always_comb begin
    ndig_new = NDIG_W'(1);
    for (int i = 0; i < INT_DIGITS; i++) begin
      if (dig_int[i] != 4'd0) begin
        ndig_new = NDIG_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    ch         = CH_ZERO;
    emit       = (state != SER_IDLE) && (!out_valid || !out_stall);
    last_char  = (state == SER_FRAC) && (idx == IDX_W'(FRACTION_DIGITS - 1));
    load       = (state == SER_IDLE) || (emit && last_char);
    unique case (state)
      SER_IDLE: begin
        ch = CH_ZERO;
      end
      SER_SIGN: begin
        ch = CH_MINUS;
        if (emit) begin
          state_next = SER_INT;
        end
      end
      SER_INT: begin
        ch = CH_ZERO + {4'd0, buf_idig[idx[INT_IDX_W-1:0]]};
        if (emit) begin
          if (idx == '0) begin
            state_next = SER_DOT;
          end else begin
            idx_next = idx - 1'b1;
          end
        end
      end
      SER_DOT: begin
        ch = CH_DOT;
        if (emit) begin
          state_next = SER_FRAC;
          idx_next   = '0;
        end
      end
      SER_FRAC: begin
        ch = CH_ZERO + {4'd0, buf_fdig[idx[FRAC_IDX_W-1:0]]};
        if (emit && !last_char) begin
          idx_next = idx + 1'b1;
        end
      end
    endcase
    if (load) begin
      if (dig_valid) begin
        state_next = dig_neg ? SER_SIGN : SER_INT;
        idx_next   = IDX_W'(ndig_new - 1'b1);
      end else begin
        state_next = SER_IDLE;
      end
    end
  end

  assign dig_take = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SER_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (load && dig_valid) begin
      buf_idig <= dig_int;
      buf_fdig <= dig_frac;
      buf_ndig <= ndig_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      character <= ch;
      last      <= last_char;
    end
  end

  `ASSERT_IMPLIES(a_last_is_digit, out_valid && last, character >= CH_ZERO && character <= CH_NINE, "last set on a non-digit character")
  `ASSERT_IMPLIES(a_int_idx_range, state == SER_INT, idx < IDX_W'(buf_ndig), "integer digit index beyond digit count")
  `ASSERT_NEXT(a_dot_then_frac, emit && state == SER_DOT, state == SER_FRAC && idx == '0, "fraction did not start after the point")

endmodule

`default_nettype wire

[hdl/fpdt_digit_pipe.sv]
// ----------------------------------------------------------------------------
// fpdt_digit_pipe
// Magnitude stage followed by one stage per integer digit. Each digit stage
// divides the integer part by ten and produces a share of the fraction digits.
// ----------------------------------------------------------------------------
`default_nettype none

module fpdt_digit_pipe import fpdt_pkg::*; #(
  parameter int FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [31:0]                    value,
  output logic                                       dig_valid,
  input  wire logic                                  dig_take,
  output logic                                       neg,
  output logic [INT_DIGITS-1:0][3:0]                 int_digits,
  output logic [FRACTION_DIGITS-1:0][3:0]            frac_digits
);

  localparam int NSTG = INT_DIGITS + 1;
  localparam int FPS  = (FRACTION_DIGITS + INT_DIGITS - 1) / INT_DIGITS;

  logic                               st_valid [NSTG];
  logic                               st_neg   [NSTG];
  logic [15:0]                        st_whole [NSTG];
  logic [15:0]                        st_frac  [NSTG];
  logic [INT_DIGITS-1:0][3:0]         st_idig  [NSTG];
  logic [FRACTION_DIGITS-1:0][3:0]    st_fdig  [NSTG];

  logic                               ready     [NSTG];
  logic [15:0]                        nxt_whole [NSTG];
  logic [15:0]                        nxt_frac  [NSTG];
  logic [INT_DIGITS-1:0][3:0]         nxt_idig  [NSTG];
  logic [FRACTION_DIGITS-1:0][3:0]    nxt_fdig  [NSTG];
  logic [31:0]                        raw;
  logic [31:0]                        mag;

  always_comb begin
    ready[NSTG-1] = !st_valid[NSTG-1] || dig_take;
    for (int s = NSTG - 2; s >= 0; s--) begin
      ready[s] = !st_valid[s] || ready[s+1];
    end
  end

  assign raw = value;
  assign mag = raw[31] ? (32'd0 - raw) : raw;

  always_comb begin
    logic [31:0] prod;
    logic [15:0] quot;
    logic [15:0] rem;
    logic [19:0] p;
    logic [15:0] fr;
    int          k;
    nxt_whole[0] = mag[31:16];
    nxt_frac[0]  = mag[15:0];
    nxt_idig[0]  = '0;
    nxt_fdig[0]  = '0;
    for (int s = 1; s < NSTG; s++) begin
      prod = {16'd0, st_whole[s-1]} * {16'd0, DIV10_MUL};
      quot = 16'(prod >> DIV10_SHIFT);
      rem  = st_whole[s-1] - ((quot << 3) + (quot << 1));
      nxt_whole[s] = quot;
      nxt_idig[s]  = st_idig[s-1];
      nxt_idig[s][s-1] = rem[3:0];
      fr = st_frac[s-1];
      nxt_fdig[s] = st_fdig[s-1];
      for (int j = 0; j < FPS; j++) begin
        k = (s - 1) * FPS + j;
        if (k < FRACTION_DIGITS) begin
          p = ({4'd0, fr} << 3) + ({4'd0, fr} << 1);
          nxt_fdig[s][k] = p[19:16];
          fr = p[15:0];
        end
      end
      nxt_frac[s] = fr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NSTG; s++) begin
        st_valid[s] <= 1'b0;
      end
    end else begin
      if (ready[0]) begin
        st_valid[0] <= in_valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (ready[s]) begin
          st_valid[s] <= st_valid[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      st_neg[0] <= raw[31];
    end
    for (int s = 0; s < NSTG; s++) begin
      if (ready[s]) begin
        st_whole[s] <= nxt_whole[s];
        st_frac[s]  <= nxt_frac[s];
        st_idig[s]  <= nxt_idig[s];
        st_fdig[s]  <= nxt_fdig[s];
      end
    end
    for (int s = 1; s < NSTG; s++) begin
      if (ready[s]) begin
        st_neg[s] <= st_neg[s-1];
      end
    end
  end

  assign in_stall    = !ready[0];
  assign dig_valid   = st_valid[NSTG-1];
  assign neg         = st_neg[NSTG-1];
  assign int_digits  = st_idig[NSTG-1];
  assign frac_digits = st_fdig[NSTG-1];

endmodule

`default_nettype wire
